/* sv/snfcs_pkg.sv */
// Shared types, codes and constants of the SPI NOR flash command sequencer.
`default_nettype none
package snfcs_pkg;

	localparam int RES_DEPTH = 4;
	localparam int RES_PW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	localparam int CFG_W  = 18;
	localparam int CFG_AW = 3;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_REPLY = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_LOAD  = 2'd3;

	localparam logic [3:0] OP_READ    = 4'd0;
	localparam logic [3:0] OP_PROGRAM = 4'd1;
	localparam logic [3:0] OP_SECTOR  = 4'd2;
	localparam logic [3:0] OP_BLK32   = 4'd3;
	localparam logic [3:0] OP_BLK64   = 4'd4;
	localparam logic [3:0] OP_CHIP    = 4'd5;
	localparam logic [3:0] OP_UNLOCK  = 4'd6;
	localparam logic [3:0] OP_ID      = 4'd7;
	localparam logic [3:0] OP_STAT1   = 4'd8;
	localparam logic [3:0] OP_STAT2   = 4'd9;
	localparam logic [3:0] OP_STAT3   = 4'd10;

	localparam logic [1:0] KIND_SPI  = 2'd0;
	localparam logic [1:0] KIND_HOST = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [7:0] SPI_WREN   = 8'h06;
	localparam logic [7:0] SPI_RDSR1  = 8'h05;
	localparam logic [7:0] SPI_RDSR2  = 8'h35;
	localparam logic [7:0] SPI_RDSR3  = 8'h15;
	localparam logic [7:0] SPI_READ   = 8'h03;
	localparam logic [7:0] SPI_PP     = 8'h02;
	localparam logic [7:0] SPI_SE     = 8'h20;
	localparam logic [7:0] SPI_BE32   = 8'h52;
	localparam logic [7:0] SPI_BE64   = 8'hd8;
	localparam logic [7:0] SPI_CE     = 8'hc7;
	localparam logic [7:0] SPI_ULBPR  = 8'h98;
	localparam logic [7:0] SPI_RDID   = 8'h90;
	localparam logic [7:0] SPI_DUMMY  = 8'hff;

	localparam int ST_BUSY_BIT = 0;
	localparam int ST_WEL_BIT  = 1;

	localparam logic [CFG_AW-1:0] CFG_EN_LIMIT   = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_PP_LIMIT   = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_SE_LIMIT   = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_B32_LIMIT  = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_B64_LIMIT  = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_CHIP_LIMIT = 3'd5;

	typedef enum logic [3:0] {
		PH_IDLE, PH_WREN, PH_EN_CMD, PH_EN_STAT, PH_EN_TICK,
		PH_FRAME, PH_DATA, PH_BUSY_CMD, PH_BUSY_STAT, PH_BUSY_TICK
	} phase_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  op;
		logic [23:0] address;
		logic [15:0] length;
		logic        wait_req;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] spi_out;
		logic       release_select;
		logic [7:0] host_byte;
		logic       success;
		logic       last;
	} res_t;

	function automatic logic [7:0] op_opcode(input logic [3:0] op);
		logic [7:0] b;
		case (op)
			OP_READ:    b = SPI_READ;
			OP_PROGRAM: b = SPI_PP;
			OP_SECTOR:  b = SPI_SE;
			OP_BLK32:   b = SPI_BE32;
			OP_BLK64:   b = SPI_BE64;
			OP_CHIP:    b = SPI_CE;
			OP_UNLOCK:  b = SPI_ULBPR;
			OP_ID:      b = SPI_RDID;
			OP_STAT1:   b = SPI_RDSR1;
			OP_STAT2:   b = SPI_RDSR2;
			OP_STAT3:   b = SPI_RDSR3;
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* sv/snfcs_res_fifo.sv */
// Small result queue that takes up to two results a cycle and hands out one while out_ready is high.
`default_nettype none
module snfcs_res_fifo
	import snfcs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_n,
	input  wire res_t       din0,
	input  wire res_t       din1,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_ready,
	output res_t            dout
);

	res_t              slot_q [RES_DEPTH];
	logic [RES_PW-1:0] wp_q;
	logic [RES_PW-1:0] rp_q;
	logic [RES_CW-1:0] count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign dout      = slot_q[rp_q];
	assign room      = (count_q <= RES_CW'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			slot_q[wp_q] <= din0;
		end
		if (push_n == 2'd2) begin
			slot_q[wp_q + RES_PW'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + RES_PW'(push_n);
			rp_q    <= rp_q + RES_PW'(pop);
			count_q <= count_q + RES_CW'(push_n) - RES_CW'(pop);
		end
	end

endmodule
`default_nettype wire

/* sv/snfcs_seq_core.sv */
// Operation sequencer: state, poll limits, page buffer and result building.
`default_nettype none
module snfcs_seq_core
	import snfcs_pkg::*;
#(
	parameter int PAGE_BYTES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire item_t             item,
	input  wire logic              cfg_en,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]  cfg_data,
	output logic [1:0]             push_n,
	output res_t                   res0,
	output res_t                   res1
);

	localparam int AW = $clog2(PAGE_BYTES);
	localparam int FW = $clog2(PAGE_BYTES + 1);

	logic [7:0]  en_lim_q;
	logic [7:0]  pp_lim_q;
	logic [15:0] se_lim_q;
	logic [15:0] b32_lim_q;
	logic [15:0] b64_lim_q;
	logic [17:0] chip_lim_q;

	phase_t      ph_q, ph_n;
	logic [3:0]  op_q, op_n;
	logic [23:0] addr_q, addr_n;
	logic [15:0] left_q, left_n;
	logic [2:0]  fidx_q, fidx_n;
	logic [17:0] polls_q, polls_n;
	logic        wait_q, wait_n;
	logic [FW-1:0] fill_q, fill_n;
	logic        mem_we;

	logic [7:0]  page_mem [PAGE_BYTES];
	logic [7:0]  rd_q;
	logic [AW-1:0] rd_addr;
	logic [15:0] rd_idx;

	logic        idle;
	logic [3:0]  sf_op;
	logic [15:0] sf_len;
	logic [15:0] sf_left;
	logic [2:0]  sf_hlen;
	logic [2:0]  hlen;
	logic [2:0]  fidx_inc;
	logic [15:0] left_dec;
	logic [17:0] polls_inc;
	logic [17:0] en_lim;
	logic [17:0] busy_lim;
	logic        finish_busy;
	logic        start_ok;
	logic        start_wren;
	logic [7:0]  data_v;
	res_t        fin_res;
	res_t        sf_res;

	function automatic logic [2:0] hdr_len(input logic [3:0] op);
		return (op == OP_CHIP || op == OP_UNLOCK || op >= OP_STAT1) ? 3'd1 : 3'd4;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [3:0] op, input logic [1:0] idx,
			input logic [23:0] a);
		logic [7:0] b;
		if (idx == 2'd0) b = op_opcode(op);
		else if (op == OP_ID) b = 8'h00;
		else if (idx == 2'd1) b = a[23:16];
		else if (idx == 2'd2) b = a[15:8];
		else b = a[7:0];
		return b;
	endfunction

	function automatic logic [15:0] data_count(input logic [3:0] op, input logic [15:0] len,
			input logic [FW-1:0] fill);
		logic [15:0] c;
		if (op == OP_READ) c = len;
		else if (op == OP_PROGRAM) c = 16'(fill);
		else if (op == OP_ID) c = 16'd2;
		else if (op >= OP_STAT1) c = 16'd1;
		else c = 16'd0;
		return c;
	endfunction

	function automatic res_t mk_spi(input logic [7:0] b, input logic rel);
		res_t r;
		r = '0;
		r.kind           = KIND_SPI;
		r.spi_out        = b;
		r.release_select = rel;
		return r;
	endfunction

	function automatic res_t mk_host(input logic [7:0] b);
		res_t r;
		r = '0;
		r.kind      = KIND_HOST;
		r.host_byte = b;
		return r;
	endfunction

	function automatic res_t mk_done(input logic ok);
		res_t r;
		r = '0;
		r.kind    = KIND_DONE;
		r.success = ok;
		return r;
	endfunction

	always_comb begin
		case (op_q)
			OP_PROGRAM: busy_lim = 18'(pp_lim_q);
			OP_SECTOR:  busy_lim = 18'(se_lim_q);
			OP_BLK32:   busy_lim = 18'(b32_lim_q);
			OP_BLK64:   busy_lim = 18'(b64_lim_q);
			default:    busy_lim = chip_lim_q;
		endcase
	end

	assign idle        = (ph_q == PH_IDLE);
	assign sf_op       = idle ? item.op : op_q;
	assign sf_len      = idle ? item.length : left_q;
	assign sf_left     = data_count(sf_op, sf_len, fill_q);
	assign sf_hlen     = hdr_len(sf_op);
	assign sf_res      = mk_spi(hdr_byte(sf_op, 2'd0, addr_q),
	                            sf_hlen == 3'd1 && sf_left == 16'd0);
	assign hlen        = hdr_len(op_q);
	assign fidx_inc    = fidx_q + 3'd1;
	assign left_dec    = left_q - 16'd1;
	assign polls_inc   = polls_q + 18'd1;
	assign en_lim      = 18'(en_lim_q);
	assign finish_busy = (op_q == OP_CHIP) ||
	                     (wait_q && op_q >= OP_PROGRAM && op_q <= OP_BLK64);
	assign start_ok    = (item.op <= OP_STAT3);
	assign start_wren  = (item.op >= OP_PROGRAM && item.op <= OP_UNLOCK);
	assign data_v      = (op_q == OP_PROGRAM) ? rd_q : SPI_DUMMY;
	assign fin_res     = finish_busy ? ((busy_lim == 18'd0) ? mk_done(1'b0)
	                                                        : mk_spi(SPI_RDSR1, 1'b0))
	                                 : mk_done(1'b1);

	// Next state.
	always_comb begin
		ph_n    = ph_q;
		op_n    = op_q;
		addr_n  = addr_q;
		left_n  = left_q;
		fidx_n  = fidx_q;
		polls_n = polls_q;
		wait_n  = wait_q;
		fill_n  = fill_q;
		mem_we  = 1'b0;
		if (fire) begin
			case (item.cmd)
				CMD_START: begin
					if (idle && start_ok) begin
						op_n   = item.op;
						addr_n = item.address;
						wait_n = item.wait_req;
						if (start_wren) begin
							ph_n   = PH_WREN;
							left_n = item.length;
						end else begin
							ph_n   = PH_FRAME;
							left_n = sf_left;
							fidx_n = 3'd0;
						end
					end
				end
				CMD_LOAD: begin
					if (idle && fill_q < FW'(PAGE_BYTES)) begin
						mem_we = 1'b1;
						fill_n = fill_q + FW'(1);
					end
				end
				CMD_TICK: begin
					if (ph_q == PH_EN_TICK) ph_n = PH_EN_CMD;
					else if (ph_q == PH_BUSY_TICK) ph_n = PH_BUSY_CMD;
				end
				default: begin
					case (ph_q)
						PH_WREN: begin
							polls_n = 18'd0;
							ph_n    = (en_lim == 18'd0) ? PH_IDLE : PH_EN_CMD;
						end
						PH_EN_CMD: ph_n = PH_EN_STAT;
						PH_EN_STAT: begin
							if (item.data[ST_WEL_BIT]) begin
								ph_n   = PH_FRAME;
								left_n = sf_left;
								fidx_n = 3'd0;
							end else begin
								polls_n = polls_inc;
								ph_n    = (polls_inc >= en_lim) ? PH_IDLE : PH_EN_TICK;
							end
						end
						PH_FRAME, PH_DATA: begin
							if (ph_q == PH_FRAME && fidx_inc < hlen) begin
								fidx_n = fidx_inc;
							end else if (ph_q == PH_FRAME && left_q != 16'd0) begin
								ph_n = PH_DATA;
							end else if (ph_q == PH_DATA && left_dec != 16'd0) begin
								left_n = left_dec;
							end else begin
								if (ph_q == PH_DATA) left_n = left_dec;
								if (op_q == OP_PROGRAM) fill_n = '0;
								if (finish_busy) begin
									polls_n = 18'd0;
									ph_n    = (busy_lim == 18'd0) ? PH_IDLE : PH_BUSY_CMD;
								end else begin
									ph_n = PH_IDLE;
								end
							end
						end
						PH_BUSY_CMD: ph_n = PH_BUSY_STAT;
						PH_BUSY_STAT: begin
							if (!item.data[ST_BUSY_BIT]) begin
								ph_n = PH_IDLE;
							end else begin
								polls_n = polls_inc;
								ph_n    = (polls_inc >= busy_lim) ? PH_IDLE : PH_BUSY_TICK;
							end
						end
						default: ph_n = ph_q;
					endcase
				end
			endcase
		end
	end

	// Results.
	always_comb begin
		res0   = '0;
		res1   = '0;
		push_n = 2'd0;
		if (fire) begin
			case (item.cmd)
				CMD_START: begin
					if (idle) begin
						push_n = 2'd1;
						if (!start_ok) res0 = mk_done(1'b0);
						else if (start_wren) res0 = mk_spi(SPI_WREN, 1'b1);
						else res0 = sf_res;
					end
				end
				CMD_LOAD: push_n = 2'd0;
				CMD_TICK: begin
					if (ph_q == PH_EN_TICK || ph_q == PH_BUSY_TICK) begin
						push_n = 2'd1;
						res0   = mk_spi(SPI_RDSR1, 1'b0);
					end
				end
				default: begin
					case (ph_q)
						PH_WREN: begin
							push_n = 2'd1;
							res0   = (en_lim == 18'd0) ? mk_done(1'b0) : mk_spi(SPI_RDSR1, 1'b0);
						end
						PH_EN_CMD, PH_BUSY_CMD: begin
							push_n = 2'd1;
							res0   = mk_spi(SPI_DUMMY, 1'b1);
						end
						PH_EN_STAT: begin
							if (item.data[ST_WEL_BIT]) begin
								push_n = 2'd1;
								res0   = sf_res;
							end else if (polls_inc >= en_lim) begin
								push_n = 2'd1;
								res0   = mk_done(1'b0);
							end
						end
						PH_FRAME: begin
							push_n = 2'd1;
							if (fidx_inc < hlen) begin
								res0 = mk_spi(hdr_byte(op_q, fidx_inc[1:0], addr_q),
								              fidx_inc + 3'd1 == hlen && left_q == 16'd0);
							end else if (left_q != 16'd0) begin
								res0 = mk_spi(data_v, left_q == 16'd1);
							end else begin
								res0 = fin_res;
							end
						end
						PH_DATA: begin
							if (op_q != OP_PROGRAM) begin
								push_n = 2'd2;
								res0   = mk_host(item.data);
								res1   = (left_dec != 16'd0) ? mk_spi(data_v, left_dec == 16'd1)
								                             : fin_res;
							end else begin
								push_n = 2'd1;
								res0   = (left_dec != 16'd0) ? mk_spi(data_v, left_dec == 16'd1)
								                             : fin_res;
							end
						end
						PH_BUSY_STAT: begin
							if (!item.data[ST_BUSY_BIT]) begin
								push_n = 2'd1;
								res0   = mk_done(1'b1);
							end else if (polls_inc >= busy_lim) begin
								push_n = 2'd1;
								res0   = mk_done(1'b0);
							end
						end
						default: push_n = 2'd0;
					endcase
				end
			endcase
			if (push_n == 2'd1) res0.last = 1'b1;
			if (push_n == 2'd2) res1.last = 1'b1;
		end
	end

	// The page byte for the next data send is fetched from the state being entered.
	assign rd_idx  = 16'(fill_n) - left_n + 16'(ph_n == PH_DATA);
	assign rd_addr = AW'(rd_idx);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			page_mem[fill_q[AW-1:0]] <= item.data;
		end
		rd_q <= page_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			op_q    <= '0;
			addr_q  <= '0;
			left_q  <= '0;
			fidx_q  <= '0;
			polls_q <= '0;
			wait_q  <= 1'b0;
			fill_q  <= '0;
		end else begin
			ph_q    <= ph_n;
			op_q    <= op_n;
			addr_q  <= addr_n;
			left_q  <= left_n;
			fidx_q  <= fidx_n;
			polls_q <= polls_n;
			wait_q  <= wait_n;
			fill_q  <= fill_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_lim_q   <= 8'd4;
			pp_lim_q   <= 8'd4;
			se_lim_q   <= 16'd440;
			b32_lim_q  <= 16'd1760;
			b64_lim_q  <= 16'd2200;
			chip_lim_q <= 18'd200000;
		end else if (cfg_en) begin
			case (cfg_addr)
				CFG_EN_LIMIT:   en_lim_q   <= cfg_data[7:0];
				CFG_PP_LIMIT:   pp_lim_q   <= cfg_data[7:0];
				CFG_SE_LIMIT:   se_lim_q   <= cfg_data[15:0];
				CFG_B32_LIMIT:  b32_lim_q  <= cfg_data[15:0];
				CFG_B64_LIMIT:  b64_lim_q  <= cfg_data[15:0];
				CFG_CHIP_LIMIT: chip_lim_q <= cfg_data;
				default:        en_lim_q   <= en_lim_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/spi_nor_flash_command_sequencer.sv */
// Top level of the SPI NOR flash command sequencer.
// A request is registered on acceptance and handled once the result queue has room; its
// results are written into the result queue, from which they are offered. One request
// is taken every cycle while the four-entry result queue has room for two results;
// results leave one per cycle while out_ready is high. Asynchronous reset clears control
// state and loads the default poll limits; the page buffer contents are not cleared.
`default_nettype none
module spi_nor_flash_command_sequencer
	import snfcs_pkg::*;
#(
	parameter int PAGE_BYTES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        cmd,
	input  wire logic [3:0]        op,
	input  wire logic [23:0]       address,
	input  wire logic [15:0]       length,
	input  wire logic              wait_req,
	input  wire logic [7:0]        data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             kind,
	output logic [7:0]             spi_out,
	output logic                   release_select,
	output logic [7:0]             host_byte,
	output logic                   success,
	output logic                   last,
	input  wire logic              cfg_en,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	logic       v_s1;
	item_t      item_s1;
	logic       room;
	logic       fire;
	logic [1:0] push_n;
	res_t       res0;
	res_t       res1;
	res_t       head;

	assign fire     = v_s1 && room;
	assign in_ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{cmd: cmd, op: op, address: address, length: length,
			             wait_req: wait_req, data: data};
		end
	end

	snfcs_seq_core #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.cfg_en  (cfg_en),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.push_n  (push_n),
		.res0    (res0),
		.res1    (res1)
	);

	snfcs_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.din0     (res0),
		.din1     (res1),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dout     (head)
	);

	assign kind           = head.kind;
	assign spi_out        = head.spi_out;
	assign release_select = head.release_select;
	assign host_byte      = head.host_byte;
	assign success        = head.success;
	assign last           = head.last;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench of the SPI NOR flash command sequencer, with an acting flash device.
`timescale 1ns / 100ps
module tb_top
	import snfcs_pkg::*;
();

	localparam int PAGE_BYTES = 256;
	localparam int PAGE_AW = $clog2(PAGE_BYTES);
	localparam int TRAFFIC_ITEMS = 110;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [1:0] cmd = CMD_START;
	logic [3:0] op = OP_READ;
	logic [23:0] address = '0;
	logic [15:0] length = '0;
	logic wait_req = 1'b0;
	logic [7:0] data = '0;
	logic out_ready = 1'b0;
	logic cfg_en = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = CFG_EN_LIMIT;
	logic [CFG_W-1:0] cfg_data = '0;

	logic in_ready;
	logic out_valid;
	logic [1:0] kind;
	logic [7:0] spi_out;
	logic release_select;
	logic [7:0] host_byte;
	logic success;
	logic last;

	// Predicted sequencer state, kept in step with every accepted request.
	phase_t pred_phase = PH_IDLE;
	logic [3:0] pred_op = OP_READ;
	logic [23:0] pred_addr = '0;
	int pred_left = 0;
	int pred_frame = 0;
	int pred_polls = 0;
	logic pred_wait = 1'b0;
	logic [7:0] page_mem [PAGE_BYTES];
	int page_fill = 0;
	int poll_limit [0:5] = '{4, 4, 440, 1760, 2200, 200000};

	res_t pending_results [$];
	int mismatch_count = 0;
	int results_checked = 0;
	int items_sent = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	bit hold_request = 1'b0;
	int hold_left = 0;

	spi_nor_flash_command_sequencer #(
		.PAGE_BYTES(PAGE_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.op(op),
		.address(address),
		.length(length),
		.wait_req(wait_req),
		.data(data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.spi_out(spi_out),
		.release_select(release_select),
		.host_byte(host_byte),
		.success(success),
		.last(last),
		.cfg_en(cfg_en),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic item_t make_item(logic [1:0] c, logic [3:0] o, logic [23:0] a,
			logic [15:0] len, logic w, logic [7:0] d);
		item_t it;
		it.cmd = c;
		it.op = o;
		it.address = a;
		it.length = len;
		it.wait_req = w;
		it.data = d;
		return it;
	endfunction

	function automatic item_t random_item();
		return make_item(2'($urandom_range(3)), 4'($urandom_range(15)),
			24'($urandom_range(24'hffffff)), 16'($urandom_range(16'hffff)),
			1'($urandom_range(1)), 8'($urandom_range(255)));
	endfunction

	function automatic void expect_result(logic [1:0] k, logic [7:0] s, logic r,
			logic [7:0] h, logic ok);
		res_t e;
		e.kind = k;
		e.spi_out = s;
		e.release_select = r;
		e.host_byte = h;
		e.success = ok;
		e.last = 1'b0;
		pending_results.push_back(e);
	endfunction

	function automatic void finish_op(logic ok);
		pred_phase = PH_IDLE;
		expect_result(KIND_DONE, 8'h00, 1'b0, 8'h00, ok);
	endfunction

	function automatic int header_len();
		if (pred_op == OP_CHIP || pred_op == OP_UNLOCK || pred_op >= OP_STAT1)
			return 1;
		return 4;
	endfunction

	function automatic logic [7:0] header_byte(int idx);
		logic [7:0] b;
		if (idx == 0) begin
			case (pred_op)
				OP_READ:    b = SPI_READ;
				OP_PROGRAM: b = SPI_PP;
				OP_SECTOR:  b = SPI_SE;
				OP_BLK32:   b = SPI_BE32;
				OP_BLK64:   b = SPI_BE64;
				OP_CHIP:    b = SPI_CE;
				OP_UNLOCK:  b = SPI_ULBPR;
				OP_ID:      b = SPI_RDID;
				OP_STAT1:   b = SPI_RDSR1;
				OP_STAT2:   b = SPI_RDSR2;
				default:    b = SPI_RDSR3;
			endcase
		end else if (pred_op == OP_ID) begin
			b = 8'h00;
		end else if (idx == 1) begin
			b = pred_addr[23:16];
		end else if (idx == 2) begin
			b = pred_addr[15:8];
		end else begin
			b = pred_addr[7:0];
		end
		return b;
	endfunction

	function automatic int busy_limit();
		case (pred_op)
			OP_PROGRAM: return poll_limit[CFG_PP_LIMIT];
			OP_SECTOR:  return poll_limit[CFG_SE_LIMIT];
			OP_BLK32:   return poll_limit[CFG_B32_LIMIT];
			OP_BLK64:   return poll_limit[CFG_B64_LIMIT];
			default:    return poll_limit[CFG_CHIP_LIMIT];
		endcase
	endfunction

	function automatic void send_data_byte();
		logic [7:0] v;
		v = SPI_DUMMY;
		if (pred_op == OP_PROGRAM)
			v = page_mem[PAGE_AW'(page_fill - pred_left)];
		pred_phase = PH_DATA;
		expect_result(KIND_SPI, v, pred_left == 1, 8'h00, 1'b0);
	endfunction

	function automatic void open_frame();
		if (pred_op == OP_PROGRAM)
			pred_left = page_fill;
		else if (pred_op == OP_ID)
			pred_left = 2;
		else if (pred_op >= OP_STAT1)
			pred_left = 1;
		else if (pred_op != OP_READ)
			pred_left = 0;
		pred_frame = 0;
		pred_phase = PH_FRAME;
		expect_result(KIND_SPI, header_byte(0), header_len() == 1 && pred_left == 0,
			8'h00, 1'b0);
	endfunction

	function automatic void close_frame();
		if (pred_op == OP_PROGRAM)
			page_fill = 0;
		if (pred_op == OP_CHIP || (pred_wait && pred_op >= OP_PROGRAM && pred_op <= OP_BLK64)) begin
			pred_polls = 0;
			if (busy_limit() == 0) begin
				finish_op(1'b0);
			end else begin
				pred_phase = PH_BUSY_CMD;
				expect_result(KIND_SPI, SPI_RDSR1, 1'b0, 8'h00, 1'b0);
			end
		end else begin
			finish_op(1'b1);
		end
	endfunction

	function automatic void predict_sequencer(item_t it);
		int queued;
		res_t tail;
		queued = pending_results.size();
		case (it.cmd)
			CMD_START: begin
				if (pred_phase == PH_IDLE) begin
					if (it.op > OP_STAT3) begin
						finish_op(1'b0);
					end else begin
						pred_op = it.op;
						pred_addr = it.address;
						pred_left = int'(it.length);
						pred_wait = it.wait_req;
						if (it.op >= OP_PROGRAM && it.op <= OP_UNLOCK) begin
							pred_phase = PH_WREN;
							expect_result(KIND_SPI, SPI_WREN, 1'b1, 8'h00, 1'b0);
						end else begin
							open_frame();
						end
					end
				end
			end
			CMD_LOAD: begin
				if (pred_phase == PH_IDLE && page_fill < PAGE_BYTES) begin
					page_mem[PAGE_AW'(page_fill)] = it.data;
					page_fill++;
				end
			end
			CMD_TICK: begin
				if (pred_phase == PH_EN_TICK) begin
					pred_phase = PH_EN_CMD;
					expect_result(KIND_SPI, SPI_RDSR1, 1'b0, 8'h00, 1'b0);
				end else if (pred_phase == PH_BUSY_TICK) begin
					pred_phase = PH_BUSY_CMD;
					expect_result(KIND_SPI, SPI_RDSR1, 1'b0, 8'h00, 1'b0);
				end
			end
			default: begin
				case (pred_phase)
					PH_WREN: begin
						pred_polls = 0;
						if (poll_limit[CFG_EN_LIMIT] == 0) begin
							finish_op(1'b0);
						end else begin
							pred_phase = PH_EN_CMD;
							expect_result(KIND_SPI, SPI_RDSR1, 1'b0, 8'h00, 1'b0);
						end
					end
					PH_EN_CMD: begin
						pred_phase = PH_EN_STAT;
						expect_result(KIND_SPI, SPI_DUMMY, 1'b1, 8'h00, 1'b0);
					end
					PH_EN_STAT: begin
						if (it.data[ST_WEL_BIT]) begin
							open_frame();
						end else begin
							pred_polls++;
							if (pred_polls >= poll_limit[CFG_EN_LIMIT])
								finish_op(1'b0);
							else
								pred_phase = PH_EN_TICK;
						end
					end
					PH_FRAME: begin
						if (pred_frame + 1 < header_len()) begin
							pred_frame++;
							expect_result(KIND_SPI, header_byte(pred_frame),
								pred_frame + 1 == header_len() && pred_left == 0,
								8'h00, 1'b0);
						end else if (pred_left > 0) begin
							send_data_byte();
						end else begin
							close_frame();
						end
					end
					PH_DATA: begin
						if (pred_op != OP_PROGRAM)
							expect_result(KIND_HOST, 8'h00, 1'b0, it.data, 1'b0);
						pred_left--;
						if (pred_left > 0)
							send_data_byte();
						else
							close_frame();
					end
					PH_BUSY_CMD: begin
						pred_phase = PH_BUSY_STAT;
						expect_result(KIND_SPI, SPI_DUMMY, 1'b1, 8'h00, 1'b0);
					end
					PH_BUSY_STAT: begin
						if (!it.data[ST_BUSY_BIT]) begin
							finish_op(1'b1);
						end else begin
							pred_polls++;
							if (pred_polls >= busy_limit())
								finish_op(1'b0);
							else
								pred_phase = PH_BUSY_TICK;
						end
					end
					default: ;
				endcase
			end
		endcase
		if (pending_results.size() > queued) begin
			tail = pending_results.pop_back();
			tail.last = 1'b1;
			pending_results.push_back(tail);
		end
	endfunction

	function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: kind %0d, spi %02h, host %02h",
					$time, kind, spi_out, host_byte);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("spi_out", want.spi_out, spi_out);
				check_field("release_select", 8'(want.release_select), 8'(release_select));
				check_field("host_byte", want.host_byte, host_byte);
				check_field("success", 8'(want.success), 8'(success));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (receiver_idles) begin
			out_ready <= ($urandom_range(99) >= 32);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_request(input item_t it);
		if (sender_idles && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		op <= it.op;
		address <= it.address;
		length <= it.length;
		wait_req <= it.wait_req;
		data <= it.data;
		do @(posedge clk); while (!in_ready);
		predict_sequencer(it);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_AW-1:0] idx, input int value);
		cfg_en <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		case (idx)
			CFG_EN_LIMIT, CFG_PP_LIMIT: poll_limit[idx] = value & 'hff;
			CFG_CHIP_LIMIT:             poll_limit[idx] = value & 'h3ffff;
			default:                    poll_limit[idx] = value & 'hffff;
		endcase
	endtask

	task automatic write_limits(input int en, input int pp, input int se, input int b32,
			input int b64, input int chip);
		drain_results();
		write_limit(CFG_EN_LIMIT, en);
		write_limit(CFG_PP_LIMIT, pp);
		write_limit(CFG_SE_LIMIT, se);
		write_limit(CFG_B32_LIMIT, b32);
		write_limit(CFG_B64_LIMIT, b64);
		write_limit(CFG_CHIP_LIMIT, chip);
		cfg_en <= 1'b0;
	endtask

	// The flash side: replies to each byte and ticks each poll wait, but for noise items.
	task automatic serve_flash_op(input int wel_pct, input int busy_pct, input int noise_pct);
		item_t it;
		while (pred_phase != PH_IDLE) begin
			if ($urandom_range(99) < noise_pct) begin
				it = random_item();
			end else begin
				it = random_item();
				it.cmd = CMD_REPLY;
				case (pred_phase)
					PH_EN_TICK, PH_BUSY_TICK: it.cmd = CMD_TICK;
					PH_EN_STAT: it.data[ST_WEL_BIT] = ($urandom_range(99) < wel_pct);
					PH_BUSY_STAT: it.data[ST_BUSY_BIT] = ($urandom_range(99) < busy_pct);
					default: ;
				endcase
			end
			send_request(it);
		end
	endtask

	task automatic run_flash_op(input logic [3:0] o, input logic [23:0] a,
			input logic [15:0] len, input logic w, input int wel_pct, input int busy_pct);
		send_request(make_item(CMD_START, o, a, len, w, 8'($urandom_range(255))));
		serve_flash_op(wel_pct, busy_pct, 0);
	endtask

	task automatic load_page(input int count);
		repeat (count)
			send_request(make_item(CMD_LOAD, 4'($urandom_range(15)),
				24'($urandom_range(24'hffffff)), 16'($urandom_range(16'hffff)),
				1'($urandom_range(1)), 8'($urandom_range(255))));
	endtask

	task automatic test_each_operation();
		int o;
		send_request(make_item(CMD_LOAD, OP_READ, 24'h0, 16'h0, 1'b0, 8'h00));
		send_request(make_item(CMD_LOAD, OP_READ, 24'h0, 16'h0, 1'b0, 8'hff));
		for (o = int'(OP_READ); o <= int'(OP_STAT3); o++)
			run_flash_op(4'(o), 24'($urandom_range(24'hffffff)),
				(o == OP_READ) ? 16'd3 : 16'hffff, o[0], 100, 30);
		run_flash_op(OP_SECTOR, 24'h800000, 16'h0, 1'b1, 100, 30);
		load_page(2);
		run_flash_op(OP_PROGRAM, 24'h000100, 16'h0, 1'b0, 100, 0);
		drain_results();
	endtask

	task automatic test_stray_requests();
		send_request(make_item(CMD_REPLY, OP_READ, 24'h0, 16'h0, 1'b0, 8'hff));
		send_request(make_item(CMD_TICK, OP_READ, 24'h0, 16'h0, 1'b0, 8'h00));
		send_request(make_item(CMD_START, OP_READ, 24'hffffff, 16'd2, 1'b1, 8'h00));
		send_request(make_item(CMD_START, OP_CHIP, 24'h0, 16'h0, 1'b1, 8'h00));
		send_request(make_item(CMD_LOAD, OP_READ, 24'h0, 16'h0, 1'b0, 8'h5a));
		send_request(make_item(CMD_TICK, OP_READ, 24'h0, 16'h0, 1'b0, 8'h00));
		serve_flash_op(100, 0, 0);
		send_request(make_item(CMD_START, 4'd11, 24'h0, 16'h0, 1'b0, 8'h00));
		send_request(make_item(CMD_START, 4'hf, 24'hffffff, 16'hffff, 1'b1, 8'hff));
		run_flash_op(OP_READ, 24'h000000, 16'd0, 1'b0, 100, 0);
		run_flash_op(OP_READ, 24'hffffff, 16'd1, 1'b0, 100, 0);
		drain_results();
	endtask

	task automatic test_poll_timeouts();
		write_limits(3, 2, 1, 1, 1, 2);
		load_page(3);
		run_flash_op(OP_PROGRAM, 24'h123456, 16'h0, 1'b1, 0, 0);
		run_flash_op(OP_SECTOR, 24'h010000, 16'h0, 1'b1, 100, 100);
		run_flash_op(OP_PROGRAM, 24'h654321, 16'h0, 1'b1, 100, 100);
		run_flash_op(OP_CHIP, 24'h0, 16'h0, 1'b0, 100, 100);
		run_flash_op(OP_BLK64, 24'h0, 16'h0, 1'b1, 50, 100);
		write_limits(0, 0, 0, 0, 0, 0);
		run_flash_op(OP_UNLOCK, 24'h0, 16'h0, 1'b0, 100, 0);
		write_limits(5, 0, 0, 0, 0, 0);
		run_flash_op(OP_CHIP, 24'h0, 16'h0, 1'b0, 100, 0);
		run_flash_op(OP_PROGRAM, 24'h0, 16'h0, 1'b1, 100, 0);
		run_flash_op(OP_BLK32, 24'h0, 16'h0, 1'b1, 100, 0);
		run_flash_op(OP_SECTOR, 24'h0, 16'h0, 1'b0, 100, 0);
		drain_results();
	endtask

	task automatic test_page_reuse();
		write_limits(4, 4, 440, 1760, 2200, 200000);
		load_page(12);
		run_flash_op(OP_PROGRAM, 24'hffff00, 16'h0, 1'b1, 60, 40);
		run_flash_op(OP_PROGRAM, 24'h000000, 16'h0, 1'b0, 100, 0);
		drain_results();
	endtask

	task automatic test_limit_extremes();
		write_limits(255, 255, 65535, 65535, 65535, 262143);
		run_flash_op(OP_CHIP, 24'h0, 16'h0, 1'b0, 20, 60);
		run_flash_op(OP_BLK32, 24'h7fffff, 16'h0, 1'b1, 50, 50);
		write_limits(1, 1, 1, 1, 1, 1);
		run_flash_op(OP_UNLOCK, 24'h0, 16'h0, 1'b0, 0, 0);
		run_flash_op(OP_BLK64, 24'h0, 16'h0, 1'b1, 100, 100);
		run_flash_op(OP_CHIP, 24'h0, 16'h0, 1'b0, 100, 100);
		drain_results();
	endtask

	// The receiver stalls for a long stretch while a long read keeps the sender busy.
	task automatic test_backpressure();
		sender_idles = 1'b0;
		hold_request = 1'b1;
		run_flash_op(OP_READ, 24'h00a5a5, 16'd16, 1'b0, 100, 0);
		run_flash_op(OP_ID, 24'h0, 16'h0, 1'b0, 100, 0);
		sender_idles = 1'b1;
		drain_results();
	endtask

	task automatic random_operation();
		logic [3:0] o;
		logic [15:0] len;
		if ($urandom_range(19) == 0) begin
			send_request(random_item());
			serve_flash_op(70, 50, 6);
		end
		load_page(($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4));
		if ($urandom_range(19) == 0)
			o = 4'($urandom_range(11, 15));
		else
			o = 4'($urandom_range(OP_READ, OP_STAT3));
		if (o == OP_READ)
			len = ($urandom_range(9) == 0) ? 16'($urandom_range(9, 64)) : 16'($urandom_range(8));
		else
			len = 16'($urandom_range(16'hffff));
		send_request(make_item(CMD_START, o, 24'($urandom_range(24'hffffff)), len,
			1'($urandom_range(1)), 8'($urandom_range(255))));
		serve_flash_op(70, 50, 6);
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			random_operation();
	endtask

	task automatic test_random_traffic();
		int share;
		share = TRAFFIC_ITEMS / 4;
		write_limits($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 20),
			$urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 20));
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		random_phase(share);
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		write_limits($urandom_range(262143), $urandom_range(262143), $urandom_range(262143),
			$urandom_range(262143), $urandom_range(262143), $urandom_range(262143));
		random_phase(share);
		write_limits(255, 255, 65535, 65535, 65535, 262143);
		random_phase(share);
		write_limits(1, 1, 1, 1, 1, 1);
		random_phase(share);
		drain_results();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_each_operation();
		test_stray_requests();
		test_poll_timeouts();
		test_page_reuse();
		test_limit_extremes();
		test_backpressure();
		test_random_traffic();
		$display("Sent %0d requests and checked %0d results over all operations, unknown codes,",
			items_sent, results_checked);
		$display("poll timeouts, zero and extreme limits, page buffer reuse and a long stall.");
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
sv/snfcs_pkg.sv
sv/snfcs_res_fifo.sv
sv/snfcs_seq_core.sv
sv/spi_nor_flash_command_sequencer.sv
dv/tb_top.sv
